// ===== src/wto_pkg.sv =====
// Shared types and constants for the wavetable oscillator.
// Holds field widths, register indexes, datapath commands and controller states.
// No dependencies.
`default_nettype none

package wto_pkg;

  // Defaults for the top-level parameters
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int ENTRY_W    = 16;
  localparam int ADDR_IN_W  = 10;
  localparam int PHASE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int AMP_W      = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Internal arithmetic widths: cubic coefficients and wide multiplier operand
  localparam int COEF_W  = 20;
  localparam int MUL_A_W = 34;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFS   = 2'd3;

  // Register reset values
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
  localparam logic [AMP_W-1:0]  AMP_UNITY  = 16'h8000;

  // Datapath operation per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_C3T,
    OP_ADD_C2,
    OP_MUL_HT,
    OP_ADD_C1,
    OP_ADD_C0,
    OP_MUL_HAMP,
    OP_NORM,
    OP_MUL_RECIP,
    OP_OUT_CUBIC,
    OP_MUL_LIN,
    OP_ADD_LIN,
    OP_OUT_LIN
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    logic       tick;
    logic       wr_en;
    logic       rd_en;
    logic [1:0] rd_sel;
    dp_op_t     op;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_write;
    logic cubic;
    logic out_free;
  } dp_stat_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_CAPD,
    S_C3T,
    S_C2,
    S_HT1,
    S_C1,
    S_HT2,
    S_C0,
    S_HAMP,
    S_NORM,
    S_RECIP,
    S_OUTC,
    S_LMUL,
    S_LADD,
    S_OUTL
  } ctrl_state_t;

endpackage

`default_nettype wire

// ===== src/wto_ram.sv =====
// Generic single-port RAM with registered read data.
// Used for the wave table; no dependencies.
`default_nettype none

module wto_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/wto_ctrl.sv =====
// Sequencer for the wavetable oscillator: one item at a time.
// Depends on wto_pkg for states, commands and status.
`default_nettype none

module wto_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wto_pkg::dp_stat_t  stat,
  output wto_pkg::dp_cmd_t   cmd
);

  import wto_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (stat.item_write) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.tick   = 1'b1;
            state_next = S_RD0;
          end
        end
      end
      // Fetch the four neighbors, previous entry first
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd0;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd2;
        state_next = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd3;
        state_next = stat.cubic ? S_CAPD : S_LMUL;
      end
      S_CAPD: begin
        state_next = S_C3T;
      end
      // Cubic: Horner steps on the shared multiplier
      S_C3T: begin
        cmd.op     = OP_MUL_C3T;
        state_next = S_C2;
      end
      S_C2: begin
        cmd.op     = OP_ADD_C2;
        state_next = S_HT1;
      end
      S_HT1: begin
        cmd.op     = OP_MUL_HT;
        state_next = S_C1;
      end
      S_C1: begin
        cmd.op     = OP_ADD_C1;
        state_next = S_HT2;
      end
      S_HT2: begin
        cmd.op     = OP_MUL_HT;
        state_next = S_C0;
      end
      S_C0: begin
        cmd.op     = OP_ADD_C0;
        state_next = S_HAMP;
      end
      S_HAMP: begin
        cmd.op     = OP_MUL_HAMP;
        state_next = stat.cubic ? S_NORM : S_OUTL;
      end
      S_NORM: begin
        cmd.op     = OP_NORM;
        state_next = S_RECIP;
      end
      S_RECIP: begin
        cmd.op     = OP_MUL_RECIP;
        state_next = S_OUTC;
      end
      // Hold here until the output register can take the sample
      S_OUTC: begin
        cmd.op = OP_OUT_CUBIC;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      // Linear and truncating path
      S_LMUL: begin
        cmd.op     = OP_MUL_LIN;
        state_next = S_LADD;
      end
      S_LADD: begin
        cmd.op     = OP_ADD_LIN;
        state_next = S_HAMP;
      end
      S_OUTL: begin
        cmd.op = OP_OUT_LIN;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/wto_dp.sv =====
// Datapath of the wavetable oscillator: registers, phase, table RAM, multiplier, output.
// Depends on wto_pkg and wto_ram; driven by wto_ctrl commands.
`default_nettype none

module wto_dp #(
  parameter int TABLE_DEPTH = wto_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = wto_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [wto_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [wto_pkg::CFG_DATA_W-1:0]          cfg_data,
  input  logic                                    operation,
  input  logic [wto_pkg::ADDR_IN_W-1:0]           table_address,
  input  logic signed [wto_pkg::ENTRY_W-1:0]      table_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [SAMPLE_BITS-1:0]           sample,
  input  wto_pkg::dp_cmd_t                        cmd,
  output wto_pkg::dp_stat_t                       stat
);

  import wto_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int NB     = SAMPLE_BITS + 2;
  localparam int MB_W   = (NB + 2 > FRAC_W + 1) ? NB + 2 : FRAC_W + 1;
  localparam int P_W    = MUL_A_W + MB_W;
  localparam int RSH    = NB + 1;
  localparam int RECIP  = (2 ** RSH + 2) / 3;
  localparam int S_MAX  = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int S_MIN  = -(2 ** (SAMPLE_BITS - 1));
  localparam int LIN_SH = FRAC_W + AMP_W - 1;

  localparam logic signed [MB_W-1:0]   RECIP_S  = MB_W'(RECIP);
  localparam logic signed [P_W-1:0]    HALF_FR  = P_W'(2 ** (FRAC_W - 1));
  localparam logic signed [P_W-1:0]    HALF_LIN = P_W'(2 ** (LIN_SH - 1));
  localparam logic signed [P_W-1:0]    BIAS_C   = P_W'(3 * 2 ** (AMP_W - 1));
  localparam logic signed [P_W-1:0]    LO3      = P_W'(3 * S_MIN);
  localparam logic signed [P_W-1:0]    HI3      = P_W'(3 * S_MAX + 2);
  localparam logic signed [P_W-1:0]    YMAX     = P_W'(S_MAX);
  localparam logic signed [P_W-1:0]    YMIN     = P_W'(S_MIN);
  localparam logic signed [COEF_W-1:0] K2       = COEF_W'(2);
  localparam logic signed [COEF_W-1:0] K3       = COEF_W'(3);
  localparam logic signed [COEF_W-1:0] K6       = COEF_W'(6);

  // Configuration registers
  logic [MODE_W-1:0]   interp_mode;
  logic [AMP_W-1:0]    amplitude;
  logic [PHASE_W-1:0]  phase_inc;
  logic [PHASE_W-1:0]  phase_ofs;

  // Phase state
  logic [PHASE_W-1:0]  acc;
  logic [PHASE_W-1:0]  pos;
  logic [PHASE_W-1:0]  pos_shl;
  logic [AW-1:0]       idx;
  logic [FRAC_W-1:0]   frac;

  // Table access
  logic                ram_en;
  logic [AW-1:0]       ram_addr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                rd_pend;
  logic [1:0]          rd_slot;
  logic signed [ENTRY_W-1:0] ent [4];

  // Arithmetic
  logic signed [COEF_W-1:0]  ax, bx, cx, dx;
  logic signed [COEF_W-1:0]  c3, c2, c1, c0;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic                      mul_en;
  logic signed [P_W-1:0]     prod;
  logic signed [MUL_A_W-1:0] h;
  logic signed [P_W-1:0]     rnd16;
  logic signed [P_W-1:0]     zc_raw;
  logic signed [P_W-1:0]     zc;
  logic signed [P_W-1:0]     yl_raw;
  logic signed [P_W-1:0]     yl;
  logic [SAMPLE_BITS-1:0]    q;

  // Output
  logic                      out_free;
  logic                      load;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= MODE_RESET;
      amplitude   <= AMP_UNITY;
      phase_inc   <= '0;
      phase_ofs   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERP_MODE: interp_mode <= cfg_data[MODE_W-1:0];
        REG_AMPLITUDE:   amplitude   <= cfg_data[AMP_W-1:0];
        REG_PHASE_INC:   phase_inc   <= cfg_data;
        REG_PHASE_OFS:   phase_ofs   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the accumulator on each tick, capture the lookup position
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.tick) begin
      acc <= acc + phase_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      pos <= acc + phase_ofs;
    end
  end

  // Top bits pick the entry, the next 16 bits give the fraction
  assign idx     = pos[PHASE_W-1 -: AW];
  assign pos_shl = pos << AW;
  assign frac    = pos_shl[PHASE_W-1 -: FRAC_W];

  // Table RAM: writes come straight from the input port, reads wrap around the table
  assign ram_en   = cmd.wr_en | cmd.rd_en;
  assign ram_addr = cmd.wr_en ? AW'(table_address) : idx + AW'(cmd.rd_sel) - AW'(1);

  wto_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (cmd.wr_en),
    .addr  (ram_addr),
    .wdata (table_value),
    .rdata (ram_rdata)
  );

  // Capture the RAM read data in the cycle after each read command
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= cmd.rd_sel;
    if (rd_pend) begin
      ent[rd_slot] <= ram_rdata;
    end
  end

  // Cubic coefficients, scaled by six
  assign ax = COEF_W'(ent[0]);
  assign bx = COEF_W'(ent[1]);
  assign cx = COEF_W'(ent[2]);
  assign dx = COEF_W'(ent[3]);
  assign c3 = dx - ax + K3 * (bx - cx);
  assign c2 = K3 * (ax + cx) - K6 * bx;
  assign c1 = K6 * cx - K2 * ax - K3 * bx - dx;
  assign c0 = K6 * bx;

  // Select multiplier operands
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_MUL_C3T: begin
        mul_a = MUL_A_W'(c3);
        mul_b = MB_W'(frac);
      end
      OP_MUL_HT: begin
        mul_a = h;
        mul_b = MB_W'(frac);
      end
      OP_MUL_HAMP: begin
        mul_a = h;
        mul_b = MB_W'(amplitude);
      end
      OP_MUL_RECIP: begin
        mul_a = h;
        mul_b = RECIP_S;
      end
      OP_MUL_LIN: begin
        mul_a = MUL_A_W'(cx - bx);
        mul_b = MB_W'(frac);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Product register
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Round a Horner product back to the coefficient scale
  assign rnd16 = (prod + HALF_FR) >>> FRAC_W;

  // Cubic scale: round by the gain, then clamp so that a divide by three lands in range
  assign zc_raw = (prod + BIAS_C) >>> AMP_W;
  always_comb begin
    if (zc_raw < LO3) begin
      zc = LO3;
    end else if (zc_raw > HI3) begin
      zc = HI3;
    end else begin
      zc = zc_raw;
    end
  end

  // Working register for Horner sums, the linear blend and the divide operand
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ADD_C2: h <= MUL_A_W'(rnd16) + MUL_A_W'(c2);
      OP_ADD_C1: h <= MUL_A_W'(rnd16) + MUL_A_W'(c1);
      OP_ADD_C0: h <= MUL_A_W'(rnd16) + MUL_A_W'(c0);
      OP_NORM:   h <= MUL_A_W'(zc - LO3);
      OP_ADD_LIN: begin
        h <= (MUL_A_W'(bx) <<< FRAC_W) + (interp_mode[0] ? MUL_A_W'(prod) : '0);
      end
      default: ;
    endcase
  end

  // Linear and truncating result: round and saturate
  assign yl_raw = (prod + HALF_LIN) >>> LIN_SH;
  always_comb begin
    if (yl_raw > YMAX) begin
      yl = YMAX;
    end else if (yl_raw < YMIN) begin
      yl = YMIN;
    end else begin
      yl = yl_raw;
    end
  end

  // Quotient by three is offset by the most negative sample; flip the sign bit to undo it
  assign q = prod[RSH +: SAMPLE_BITS];

  // Output register, refilled as soon as the receiver takes the previous sample
  assign out_free = !out_valid || out_ready;
  assign load     = out_free && (cmd.op == OP_OUT_CUBIC || cmd.op == OP_OUT_LIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cmd.op == OP_OUT_CUBIC) begin
        sample <= {~q[SAMPLE_BITS-1], q[SAMPLE_BITS-2:0]};
      end else begin
        sample <= SAMPLE_BITS'(yl);
      end
    end
  end

  // Status to the controller
  assign stat.item_write = operation;
  assign stat.cubic      = interp_mode[1];
  assign stat.out_free   = out_free;

endmodule

`default_nettype wire

// ===== src/wavetable_oscillator.sv =====
// Wavetable oscillator with truncating, linear or cubic table lookup.
// Input channel (in_valid/in_ready): operation 1 writes table_value into the wave table
// at table_address; operation 0 is a tick that yields one saturated sample.
// Output channel (out_valid/out_ready) carries sample. Configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) sets mode, amplitude, phase step and offset;
// write it only while the block is idle.
// A table write is done in the idle state and leaves the block ready. A tick's
// sample is loaded into the output register in OUTL after RD0 to RD3, LMUL, LADD
// and HAMP in truncating or linear mode, and in OUTC after RD0 to RD3, CAPD, the
// Horner steps, HAMP, NORM and RECIP in cubic mode. Four table reads through the
// single RAM port and the Horner steps on one shared multiplier set the length of a tick.
// One item is in flight at a time; the next item is taken the cycle after a sample is
// loaded, even while that sample still waits on out_ready.
// When the receiver stalls and a new sample is ready, the sequencer holds in its final
// step until the output register frees.
// Reset clears the phase accumulator and the registers (unity amplitude, truncating mode);
// table contents are undefined until written.
// Depends on wto_pkg, wto_ctrl, wto_dp, wto_ram.
`default_nettype none

module wavetable_oscillator #(
  parameter int TABLE_DEPTH = wto_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = wto_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wto_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wto_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic [wto_pkg::ADDR_IN_W-1:0]      table_address,
  input  logic signed [wto_pkg::ENTRY_W-1:0] table_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      sample
);

  import wto_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  wto_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wto_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .table_address (table_address),
    .table_value   (table_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample        (sample),
    .cmd           (cmd),
    .stat          (stat)
  );

  // A table write finishes at once and never yields a sample
  a_write_no_sample: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation |=> in_ready && !$rose(out_valid))
    else $error("table write produced a sample or left the block busy");

  // A tick keeps the block busy on the following cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !operation |=> !in_ready)
    else $error("tick did not occupy the sequencer");

  // A new sample only appears at the end of a tick in progress
  a_sample_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("sample appeared while the sequencer was idle");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for wavetable_oscillator: loads the wave table, then runs ticks and table
// writes under every lookup mode and several gain/phase settings, checking each sample.
// Depends on wto_pkg and wavetable_oscillator.
module tb_top;

  localparam int DEPTH   = wto_pkg::TABLE_DEPTH_DEF;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int ADDR_W  = wto_pkg::ADDR_IN_W;
  localparam int VALUE_W = wto_pkg::ENTRY_W;

  // Item kinds carried on the operation port
  localparam logic ITEM_TICK  = 1'b0;
  localparam logic ITEM_WRITE = 1'b1;

  // Lookup modes
  localparam logic [wto_pkg::MODE_W-1:0] MODE_TRUNC     = 2'd0;
  localparam logic [wto_pkg::MODE_W-1:0] MODE_LINEAR    = 2'd1;
  localparam logic [wto_pkg::MODE_W-1:0] MODE_CUBIC     = 2'd2;
  localparam logic [wto_pkg::MODE_W-1:0] MODE_CUBIC_ALT = 2'd3;

  localparam int SETTLE_CYCLES  = 24;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 14;

  typedef struct packed {
    logic                                op;
    logic [wto_pkg::ADDR_IN_W-1:0]       addr;
    logic signed [wto_pkg::ENTRY_W-1:0]  value;
  } osc_item_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [wto_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [wto_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                operation = ITEM_TICK;
  logic [wto_pkg::ADDR_IN_W-1:0]       table_address = '0;
  logic signed [wto_pkg::ENTRY_W-1:0]  table_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [15:0]                  sample;

  // Mirror of the oscillator state and registers
  logic signed [wto_pkg::ENTRY_W-1:0]  wave_mem [DEPTH];
  logic [31:0]                         phase_acc = '0;
  logic [wto_pkg::MODE_W-1:0]          cfg_mode = MODE_TRUNC;
  logic [wto_pkg::AMP_W-1:0]           cfg_amp = wto_pkg::AMP_UNITY;
  logic [31:0]                         cfg_inc = '0;
  logic [31:0]                         cfg_ofs = '0;

  osc_item_t                           osc_items[$];
  logic [15:0]                         predicted_samples[$];

  int                                  sender_idle_pct = 0;
  int                                  recv_stall_pct = 0;
  logic                                squeeze_req = 1'b0;
  logic                                squeeze_done = 1'b0;
  int                                  squeeze_count = 0;
  int                                  quiet_cycles = 0;
  int                                  mismatch_count = 0;

  wavetable_oscillator i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .table_address (table_address),
    .table_value   (table_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample        (sample)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor((num + den/2) / den) for an even positive divisor
  function automatic longint round_div(longint num, longint den);
    longint biased;
    biased = num + den / 2;
    if (biased >= 0) return biased / den;
    return -((-biased + den - 1) / den);
  endfunction

  // Sample for the current phase, offset, mode and gain
  function automatic logic [15:0] interpolate_sample();
    logic [31:0]      pos;
    logic [IDX_W-1:0] idx, idx_m1, idx_p1, idx_p2;
    longint           frac, a, b, c, d, h, y, amp;
    pos    = phase_acc + cfg_ofs;
    idx    = pos[31 -: IDX_W];
    frac   = longint'(pos[31-IDX_W -: 16]);
    idx_m1 = idx - 1'b1;
    idx_p1 = idx + 1'b1;
    idx_p2 = idx + 2'd2;
    a      = longint'(wave_mem[idx_m1]);
    b      = longint'(wave_mem[idx]);
    c      = longint'(wave_mem[idx_p1]);
    d      = longint'(wave_mem[idx_p2]);
    amp    = longint'(cfg_amp);
    if (cfg_mode[1]) begin
      h = -a + 3 * b - 3 * c + d;
      h = round_div(h * frac, 65536) + (3 * (a + c) - 6 * b);
      h = round_div(h * frac, 65536) + (6 * c - 2 * a - 3 * b - d);
      h = round_div(h * frac, 65536) + 6 * b;
      y = round_div(h * amp, 6 * 32768);
    end else if (cfg_mode[0]) begin
      y = round_div((b * 65536 + frac * (c - b)) * amp, 64'sd2147483648);
    end else begin
      y = round_div(b * amp, 32768);
    end
    if (y > 32767) y = 32767;
    else if (y < -32768) y = -32768;
    return y[15:0];
  endfunction

  // Apply one accepted item to the mirrored state
  task automatic apply_item(osc_item_t item);
    if (item.op == ITEM_WRITE) begin
      wave_mem[item.addr] = item.value;
    end else begin
      predicted_samples.push_back(interpolate_sample());
      phase_acc = phase_acc + cfg_inc;
    end
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("[%0t] %s", $time, what);
  endtask

  // Input driver: advance to the next queued item after each transfer
  always @(posedge clk) begin : drive_items
    osc_item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        apply_item('{op: operation, addr: table_address, value: table_value});
      if (!in_valid || in_ready) begin
        if (osc_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = osc_items.pop_front();
          in_valid      <= 1'b1;
          operation     <= next_item.op;
          table_address <= next_item.addr;
          table_value   <= next_item.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each sample transfer, then pick the next ready level
  always @(posedge clk) begin : check_samples
    logic [15:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d", sample));
        end else begin
          want = predicted_samples.pop_front();
          if (sample !== want)
            report_mismatch($sformatf("sample mismatch: expected %0d, got %0d",
                                      $signed(want), sample));
        end
      end
      // Hold off for a long stretch once when asked, else stall at random
      if (squeeze_req && !squeeze_done) begin
        if (squeeze_count == SQUEEZE_CYCLES) begin
          squeeze_done <= 1'b1;
          out_ready    <= 1'b1;
        end else begin
          squeeze_count <= squeeze_count + 1;
          out_ready     <= 1'b0;
        end
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(logic op, logic [wto_pkg::ADDR_IN_W-1:0] addr,
                            logic signed [wto_pkg::ENTRY_W-1:0] value);
    osc_items.push_back('{op: op, addr: addr, value: value});
  endtask

  task automatic queue_ticks(int count);
    for (int i = 0; i < count; i++)
      queue_item(ITEM_TICK, ADDR_W'($urandom), VALUE_W'($urandom));
  endtask

  // Mostly ticks, with table rewrites that sometimes hit the value extremes
  task automatic queue_random(int count);
    int                                 pick;
    logic signed [wto_pkg::ENTRY_W-1:0] value;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        pick = $urandom_range(9);
        if (pick == 0) value = 16'sh8000;
        else if (pick == 1) value = 16'sh7FFF;
        else value = VALUE_W'($urandom);
        queue_item(ITEM_WRITE, ADDR_W'($urandom), value);
      end else begin
        queue_ticks(1);
      end
    end
  endtask

  task automatic set_register(logic [wto_pkg::CFG_IDX_W-1:0] index, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      wto_pkg::REG_INTERP_MODE: cfg_mode = data[wto_pkg::MODE_W-1:0];
      wto_pkg::REG_AMPLITUDE:   cfg_amp  = data[wto_pkg::AMP_W-1:0];
      wto_pkg::REG_PHASE_INC:   cfg_inc  = data;
      wto_pkg::REG_PHASE_OFS:   cfg_ofs  = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [1:0] mode, logic [15:0] amp, logic [31:0] inc,
                           logic [31:0] ofs);
    set_register(wto_pkg::REG_INTERP_MODE, 32'(mode));
    set_register(wto_pkg::REG_AMPLITUDE, 32'(amp));
    set_register(wto_pkg::REG_PHASE_INC, inc);
    set_register(wto_pkg::REG_PHASE_OFS, ofs);
  endtask

  task automatic set_pace(int send_pct, int stall_pct);
    @(posedge clk);
    sender_idle_pct <= send_pct;
    recv_stall_pct  <= stall_pct;
  endtask

  // Wait for all items and samples, then let a write or a tick finish inside
  task automatic settle();
    while (osc_items.size() != 0 || in_valid || predicted_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int phase);
    logic [1:0]  mode;
    logic [15:0] amp;
    logic [31:0] inc, ofs;
    mode = phase[1:0];
    case (phase)
      1:       amp = 16'hFFFF;
      3:       amp = 16'h0000;
      5:       amp = wto_pkg::AMP_UNITY;
      default: amp = 16'($urandom_range(32768));
    endcase
    case (phase)
      0:       inc = 32'hFFFF_FFFF;
      2:       inc = 32'h0;
      4:       inc = $urandom_range(32'h0040_0000);
      default: inc = $urandom;
    endcase
    case (phase)
      6:       ofs = 32'hFFFF_FFFF;
      7:       ofs = 32'h0;
      default: ofs = $urandom;
    endcase
    configure(mode, amp, inc, ofs);
    case (phase % 4)
      0:       set_pace(0, 0);
      1:       set_pace(60, 0);
      2:       set_pace(0, 60);
      default: set_pace(27, 27);
    endcase
    @(negedge clk);
    queue_random(PHASE_ITEMS);
    // Starve the output while the sender keeps offering items
    if (phase == 4) begin
      @(posedge clk);
      squeeze_req <= 1'b1;
      while (!squeeze_done) @(posedge clk);
    end
    settle();
  endtask

  initial begin : run_test
    logic signed [wto_pkg::ENTRY_W-1:0] fill_value;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Load every table entry; extremes sit around the wrap point
    @(negedge clk);
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0, DEPTH - 2: fill_value = 16'sh7FFF;
        1, DEPTH - 1: fill_value = 16'sh8000;
        default:      fill_value = VALUE_W'($urandom);
      endcase
      queue_item(ITEM_WRITE, ADDR_W'(i), fill_value);
    end
    settle();

    // Truncation, one entry per tick; a table write must not move the phase
    configure(MODE_TRUNC, wto_pkg::AMP_UNITY, 32'h0040_0000, 32'h0);
    @(negedge clk);
    queue_ticks(1);
    queue_item(ITEM_WRITE, 10'd5, 16'sh1234);
    queue_ticks(2);
    settle();

    // Linear at the last entry, wrapping to the first, with gain above unity
    configure(MODE_LINEAR, 16'hFFFF, 32'h0020_0000, 32'hFFC0_0000 - phase_acc);
    @(negedge clk);
    queue_ticks(3);
    settle();

    // Cubic across the wrap, the furthest neighbour wrapping to the first entry
    configure(MODE_CUBIC, wto_pkg::AMP_UNITY, 32'h0015_5555, 32'hFF80_0000 - phase_acc);
    @(negedge clk);
    queue_ticks(4);
    settle();

    // Mode three from the first entry, stepping backward
    configure(MODE_CUBIC_ALT, 16'd40000, 32'hFFC0_0000, 32'h0 - phase_acc);
    @(negedge clk);
    queue_ticks(3);
    settle();

    // Zero gain, largest step and offset
    configure(MODE_CUBIC, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    @(negedge clk);
    queue_ticks(2);
    settle();

    for (int p = 0; p < PHASE_COUNT; p++)
      run_phase(p);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/wto_pkg.sv
src/wto_ram.sv
src/wto_ctrl.sv
src/wto_dp.sv
src/wavetable_oscillator.sv
test/tb_top.sv
